// ----- rtl/kmsd_pkg.sv -----
// shared types and constants for the key matrix scanner with debounce
package kmsd_pkg;

    localparam int unsigned NUM_ROWS = 4;
    localparam int unsigned NUM_KEYS = 8;
    localparam int unsigned CFG_W    = 4;
    localparam int unsigned CNT_W    = 4;

    localparam logic [CFG_W-1:0] SETTLE_RESET    = 4'd2;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 4'd5;

    localparam logic [1:0] PINS_IDLE = 2'b11;
    localparam logic [1:0] PINS_COL1 = 2'b10;
    localparam logic [1:0] PINS_COL2 = 2'b01;

    localparam logic REG_SETTLE    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        PH_COL1 = 2'd0,
        PH_COL2 = 2'd1,
        PH_WAIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic       sample;
        logic       column;
        logic [1:0] pins;
    } t_scan_status;

endpackage

// ----- rtl/kmsd_scan.sv -----
// column scan sequencer: phase, settle timer, active column and pin levels
module kmsd_scan
    import kmsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [CFG_W-1:0] i_settle_ticks,
    output t_scan_status     o_status
);

    t_phase           r_phase, n_phase;
    logic [CFG_W-1:0] r_timer, n_timer;
    logic             r_column, n_column;
    logic [1:0]       r_pins, n_pins;
    logic [CFG_W-1:0] settle_load;
    logic             sample;

    assign settle_load = (i_settle_ticks == '0) ? CFG_W'(1) : i_settle_ticks;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_column = r_column;
        n_pins   = r_pins;
        case (r_phase)
            PH_COL2: begin
                n_phase  = PH_WAIT;
                n_timer  = settle_load;
                n_column = 1'b1;
                n_pins   = PINS_COL2;
            end
            PH_WAIT: begin
                if (r_timer != '0) begin
                    n_timer = r_timer - CFG_W'(1);
                end
                if (r_timer <= CFG_W'(1)) begin
                    n_phase = r_column ? PH_COL1 : PH_COL2;
                end
            end
            default: begin
                n_phase  = PH_WAIT;
                n_timer  = settle_load;
                n_column = 1'b0;
                n_pins   = PINS_COL1;
            end
        endcase
    end

    // outputs
    always_comb begin
        case (r_phase)
            PH_WAIT: sample = (r_timer <= CFG_W'(1));
            default: sample = 1'b0;
        endcase
    end

    assign o_status.sample = sample;
    assign o_status.column = r_column;
    assign o_status.pins   = n_pins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COL1;
            r_timer  <= '0;
            r_column <= 1'b0;
            r_pins   <= PINS_IDLE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_column <= n_column;
            r_pins   <= n_pins;
        end
    end

endmodule

// ----- rtl/kmsd_keys.sv -----
// per-key debounce counters, stable levels and latched events
module kmsd_keys
    import kmsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_scan_status        i_scan,
    input  logic [NUM_ROWS-1:0] i_rows,
    input  logic [NUM_KEYS-1:0] i_clear_pressed,
    input  logic [NUM_KEYS-1:0] i_clear_released,
    input  logic [CFG_W-1:0]    i_threshold,
    output logic [NUM_KEYS-1:0] o_stable,
    output logic [NUM_KEYS-1:0] o_pressed,
    output logic [NUM_KEYS-1:0] o_released
);

    logic [NUM_KEYS-1:0]            r_stable, n_stable;
    logic [NUM_KEYS-1:0]            r_pressed, n_pressed;
    logic [NUM_KEYS-1:0]            r_released, n_released;
    logic [NUM_KEYS-1:0][CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0]               thr;
    logic [CNT_W-1:0]               inc;
    logic                           now;
    logic                           in_col;

    assign thr = (i_threshold == '0) ? CNT_W'(1) : i_threshold;

    always_comb begin
        n_stable   = r_stable;
        n_pressed  = r_pressed & ~i_clear_pressed;
        n_released = r_released & ~i_clear_released;
        n_count    = r_count;
        inc        = '0;
        now        = 1'b0;
        in_col     = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            in_col = ((k >= NUM_ROWS) == i_scan.column);
            now    = i_rows[k % NUM_ROWS];
            inc    = r_count[k] + CNT_W'(1);
            if (i_scan.sample && in_col) begin
                if (now != r_stable[k]) begin
                    if (inc >= thr) begin
                        n_stable[k] = now;
                        n_count[k]  = '0;
                        if (now) begin
                            n_pressed[k] = 1'b1;
                        end else begin
                            n_released[k] = 1'b1;
                        end
                    end else begin
                        n_count[k] = inc;
                    end
                end else begin
                    n_count[k] = '0;
                end
            end
        end
    end

    assign o_stable   = n_stable;
    assign o_pressed  = n_pressed;
    assign o_released = n_released;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= '0;
            r_pressed  <= '0;
            r_released <= '0;
            r_count    <= '0;
        end else if (i_step) begin
            r_stable   <= n_stable;
            r_pressed  <= n_pressed;
            r_released <= n_released;
            r_count    <= n_count;
        end
    end

endmodule

// ----- rtl/key_matrix_scan_debounce_top.sv -----
// top level: register port, scan sequencer, key bank and result register
// an accepted request's result is registered and appears on the master side in the next cycle
// throughput: one request per cycle, bounded only by the result register handoff
// the result register frees and refills in the same cycle when the result is taken
// reset: synchronous active low, scan restarts at column one setup with both pins high
// reset clears all keys, counters and events and loads settle 2, threshold 5
module key_matrix_scan_debounce_top
    import kmsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // row_levels[3:0], clear_pressed[11:4], clear_released[19:12], zero pad
    input  logic [23:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // column_drive[1:0], stable_keys[9:2], pressed_events[17:10],
    // released_events[25:18], zero pad
    output logic [31:0] o_m_tdata,
    // rows_sampled[0]
    output logic        o_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [CFG_W-1:0]    r_settle;
    logic [CFG_W-1:0]    r_threshold;
    logic                r_out_valid;
    logic [31:0]         r_out_data;
    logic                r_out_user;
    logic                in_acc;
    logic                cfg_wr;
    t_scan_status        scan_st;
    logic [NUM_KEYS-1:0] stable;
    logic [NUM_KEYS-1:0] pressed;
    logic [NUM_KEYS-1:0] released;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= SETTLE_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (cfg_wr) begin
            case (i_paddr[2])
                REG_SETTLE:    r_settle    <= i_pwdata[CFG_W-1:0];
                REG_THRESHOLD: r_threshold <= i_pwdata[CFG_W-1:0];
                default:       r_settle    <= r_settle;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_SETTLE:    o_prdata = {28'd0, r_settle};
            REG_THRESHOLD: o_prdata = {28'd0, r_threshold};
            default:       o_prdata = '0;
        endcase
    end

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_acc     = i_s_tvalid && o_s_tready;

    kmsd_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_acc),
        .i_settle_ticks (r_settle),
        .o_status       (scan_st)
    );

    kmsd_keys u_keys (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_acc),
        .i_scan           (scan_st),
        .i_rows           (i_s_tdata[3:0]),
        .i_clear_pressed  (i_s_tdata[11:4]),
        .i_clear_released (i_s_tdata[19:12]),
        .i_threshold      (r_threshold),
        .o_stable         (stable),
        .o_pressed        (pressed),
        .o_released       (released)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= {6'd0, released, pressed, stable, scan_st.pins};
            r_out_user <= scan_st.sample;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_sample_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata[1:0] == PINS_COL1 || o_m_tdata[1:0] == PINS_COL2))
        else $error("sampled result without exactly one column driven");

    a_sample_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && scan_st.sample) |=> (r_out_valid && r_out_user))
        else $error("row sample not flagged in result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result lost or changed");

endmodule

// ----- verif/testbench.sv -----
// testbench for the key matrix scanner: directed table, then random traffic checked by a model
module testbench
    import kmsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] pins;
        logic [7:0] stable;
        logic [7:0] pressed;
        logic [7:0] released;
        logic       sampled;
    } t_key_report;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        reg_sel;
        logic [3:0]  wval;
        logic [3:0]  rows;
        logic [7:0]  clr_p;
        logic [7:0]  clr_r;
        logic        typed;
        t_key_report want;
    } t_dir_row;

    localparam t_key_report C1_IDLE = '{PINS_COL1, 8'h00, 8'h00, 8'h00, 1'b0};
    localparam t_key_report C1_SAMP = '{PINS_COL1, 8'h00, 8'h00, 8'h00, 1'b1};
    localparam int unsigned N_DIR = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    key_matrix_scan_debounce_top DUT (.*);

    // scan model state
    logic [3:0] cfg_settle = SETTLE_RESET;
    logic [3:0] cfg_thr    = THRESHOLD_RESET;
    t_phase     m_phase    = PH_COL1;
    logic [3:0] m_timer    = '0;
    logic       m_col      = 1'b0;
    logic [1:0] m_pins     = PINS_IDLE;
    logic [7:0] m_stable   = '0;
    logic [3:0] m_count [NUM_KEYS] = '{default: '0};
    logic [7:0] m_prs      = '0;
    logic [7:0] m_rel      = '0;

    t_key_report key_report_q [$];
    int          n_errors   = 0;
    bit          calm       = 1'b0;
    bit          typed_next = 1'b0;
    t_key_report typed_want = '0;

    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h0, 8'h00, 8'h00, 1'b1, C1_IDLE},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h0, 8'hFF, 8'hFF, 1'b1, C1_IDLE},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h0, 8'h00, 8'h00, 1'b1, C1_SAMP},
        // zero settle and zero threshold act as one
        '{ROW_WRITE, REG_SETTLE,    4'd0,  4'h0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, 4'd0,  4'h0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'hF, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'hF, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'hF, 8'h00, 8'h00, 1'b0, '0},
        // press latched on the same tick as its clear
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'hF, 8'hFF, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h0, 8'h00, 8'hFF, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h0, 8'hFF, 8'hFF, 1'b0, '0},
        '{ROW_WRITE, REG_THRESHOLD, 4'd15, 4'h0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_SETTLE,    4'd1,  4'h0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        // threshold dropped below the running counts
        '{ROW_WRITE, REG_THRESHOLD, 4'd1,  4'h0, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0},
        '{ROW_ITEM,  REG_SETTLE,    4'd0,  4'h5, 8'h00, 8'h00, 1'b0, '0}
    };

    function automatic t_key_report scan_tick(logic [3:0] rows, logic [7:0] cp,
                                              logic [7:0] cr);
        t_key_report r;
        logic [3:0]  thr;
        logic [3:0]  c;
        int          k;
        r = '0;
        m_prs &= ~cp;
        m_rel &= ~cr;
        if (m_phase != PH_WAIT) begin
            m_col   = (m_phase == PH_COL2);
            m_pins  = m_col ? PINS_COL2 : PINS_COL1;
            m_timer = (cfg_settle == 4'd0) ? 4'd1 : cfg_settle;
            m_phase = PH_WAIT;
        end else begin
            if (m_timer != 4'd0) m_timer = m_timer - 4'd1;
            if (m_timer == 4'd0) begin
                thr = (cfg_thr == 4'd0) ? 4'd1 : cfg_thr;
                for (int i = 0; i < NUM_ROWS; i++) begin
                    k = m_col * NUM_ROWS + i;
                    if (rows[i] != m_stable[k]) begin
                        c = m_count[k] + 4'd1;
                        if (c >= thr) begin
                            if (rows[i]) m_prs[k] = 1'b1;
                            else m_rel[k] = 1'b1;
                            m_stable[k] = rows[i];
                            c = 4'd0;
                        end
                        m_count[k] = c;
                    end else begin
                        m_count[k] = 4'd0;
                    end
                end
                m_phase  = m_col ? PH_COL1 : PH_COL2;
                r.sampled = 1'b1;
            end
        end
        r.pins     = m_pins;
        r.stable   = m_stable;
        r.pressed  = m_prs;
        r.released = m_rel;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    always @(posedge i_clk) begin : monitor
        t_key_report got;
        t_key_report want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tdata[1:0], o_m_tdata[9:2], o_m_tdata[17:10],
                        o_m_tdata[25:18], o_m_tuser};
                if (key_report_q.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending: %h", got));
                end else begin
                    want = key_report_q.pop_front();
                    if (got.pins != want.pins)
                        report_mismatch($sformatf("column_drive %h want %h",
                                                  got.pins, want.pins));
                    if (got.stable != want.stable)
                        report_mismatch($sformatf("stable_keys %h want %h",
                                                  got.stable, want.stable));
                    if (got.pressed != want.pressed)
                        report_mismatch($sformatf("pressed_events %h want %h",
                                                  got.pressed, want.pressed));
                    if (got.released != want.released)
                        report_mismatch($sformatf("released_events %h want %h",
                                                  got.released, want.released));
                    if (got.sampled != want.sampled)
                        report_mismatch($sformatf("rows_sampled %b want %b",
                                                  got.sampled, want.sampled));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                want = scan_tick(i_s_tdata[3:0], i_s_tdata[11:4], i_s_tdata[19:12]);
                if (typed_next) want = typed_want;
                key_report_q.push_back(want);
            end
        end
    end

    task automatic send_request(logic [3:0] rows, logic [7:0] cp, logic [7:0] cr);
        if (!calm && $urandom_range(0, 99) < 27) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'h0, cr, cp, rows};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic sel, logic [3:0] val);
        i_s_tvalid <= 1'b0;
        while (key_report_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {sel, 2'b00};
        i_pwdata  <= {28'h0, val};
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (sel == REG_SETTLE) cfg_settle = val;
        else cfg_thr = val;
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    initial begin
        logic [3:0] hold;
        logic [3:0] rows;
        logic [7:0] cp;
        logic [7:0] cr;
        logic [3:0] st;
        logic [3:0] th;
        int         len;
        int         pick;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        i_psel     = 1'b0;
        i_penable  = 1'b0;
        i_pwrite   = 1'b0;
        i_paddr    = '0;
        i_pwdata   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_WRITE) begin
                cfg_write(dir_rows[n].reg_sel, dir_rows[n].wval);
            end else begin
                typed_next = dir_rows[n].typed;
                typed_want = dir_rows[n].want;
                send_request(dir_rows[n].rows, dir_rows[n].clr_p, dir_rows[n].clr_r);
                typed_next = 1'b0;
            end
        end

        hold = 4'($urandom_range(0, 15));
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin st = 4'd1;  th = 4'd1;  end
                1: begin st = 4'd15; th = 4'd15; end
                2: begin st = 4'd0;  th = 4'd0;  end
                3: begin st = 4'd2;  th = 4'd5;  end
                default: begin
                    st = 4'($urandom_range(0, 15));
                    th = 4'($urandom_range(0, 15));
                end
            endcase
            cfg_write(REG_SETTLE, st);
            cfg_write(REG_THRESHOLD, th);
            calm = (p == 4);
            len  = (p == 1) ? 500 : 150;
            for (int i = 0; i < len; i++) begin
                if (p == 3 && i == 75) begin
                    // hold off until the block has drained
                    i_s_tvalid <= 1'b0;
                    while (key_report_q.size() != 0) @(negedge i_clk);
                end
                if ($urandom_range(0, 99) < 4) hold = 4'($urandom_range(0, 15));
                rows = hold;
                if ($urandom_range(0, 99) < 5) rows = rows ^ 4'($urandom_range(1, 15));
                pick = $urandom_range(0, 99);
                cp = (pick < 80) ? 8'h00 : (pick < 95) ? 8'($urandom) : 8'hFF;
                pick = $urandom_range(0, 99);
                cr = (pick < 80) ? 8'h00 : (pick < 95) ? 8'($urandom) : 8'hFF;
                send_request(rows, cp, cr);
            end
            calm = 1'b0;
        end
        i_s_tvalid <= 1'b0;

        while (key_report_q.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/kmsd_pkg.sv
rtl/kmsd_scan.sv
rtl/kmsd_keys.sv
rtl/key_matrix_scan_debounce_top.sv
verif/testbench.sv
